@@ hdl/edit_distance_similarity_unit_defines.svh @@
// assertion macros shared by the checker
`ifndef EDIT_DISTANCE_SIMILARITY_UNIT_DEFINES_SVH
`define EDIT_DISTANCE_SIMILARITY_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define EDS_ASSERT_IMP(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("edit distance unit: same-cycle check failed");

// next-cycle implication under reset
`define EDS_ASSERT_NXT(lbl, c, r, ante, cons) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("edit distance unit: next-cycle check failed");

`endif

@@ hdl/eds_pkg.sv @@
// shared constants and types of the edit distance similarity unit
package eds_pkg;

    localparam int CODE_W    = 21;
    localparam int LEN_OUT_W = 8;
    localparam int SIM_W     = 17;
    localparam int FRAC_W    = 16;

    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_SECOND  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // character compare results feeding one table cell
    typedef struct packed {
        logic sub_diff;
        logic cross_a;
        logic cross_b;
        logic trans_en;
    } eds_match_t;

endpackage

@@ hdl/eds_ram.sv @@
// generic ram, one write port and two registered read ports
module eds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/eds_cell.sv @@
// one table cell: least of insert, delete, substitute and transposition
module eds_cell #(
    parameter int W = 8
) (
    input  logic [W-1:0]        up,
    input  logic [W-1:0]        diag,
    input  logic [W-1:0]        left,
    input  logic [W-1:0]        up2,
    input  eds_pkg::eds_match_t match,
    output logic [W-1:0]        v
);

    logic [W:0] del_cost;
    logic [W:0] ins_cost;
    logic [W:0] sub_cost;
    logic [W:0] trn_cost;
    logic [W:0] m1;
    logic [W:0] m2;
    logic [W:0] m3;

    always_comb
    begin
        del_cost = {1'b0, up} + (W+1)'(1);
        ins_cost = {1'b0, left} + (W+1)'(1);
        sub_cost = {1'b0, diag} + (W+1)'(match.sub_diff);
        trn_cost = {1'b0, up2} + (W+1)'(1) + (W+1)'(match.cross_a)
                   + (W+1)'(match.cross_b);
        m1 = (ins_cost < del_cost) ? ins_cost : del_cost;
        m2 = (sub_cost < m1) ? sub_cost : m1;
        m3 = (match.trans_en && (trn_cost < m2)) ? trn_cost : m2;
        v  = m3[W-1:0];
    end

endmodule

@@ hdl/eds_divider.sv @@
// restoring divider, one quotient bit per cycle, for the q1.16 ratio
module eds_divider #(
    parameter int W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [W-1:0]               numer,
    input  logic [W-1:0]               denom,
    output logic                       done,
    output logic [eds_pkg::SIM_W-1:0]  quotient
);

    localparam int Steps = eds_pkg::SIM_W;
    localparam int CntW  = $clog2(Steps);

    logic                      run_reg;
    logic                      done_reg;
    logic [CntW-1:0]           cnt_reg;
    logic [W-1:0]              rem_reg;
    logic [W-1:0]              den_reg;
    logic [eds_pkg::SIM_W-1:0] q_reg;
    logic [W:0]                trial;
    logic                      ge;

    always_comb
    begin
        // first step is the integer bit, no shift
        trial = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CntW'(Steps - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            den_reg <= denom;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? W'(trial - {1'b0, den_reg}) : W'(trial);
            q_reg   <= {q_reg[eds_pkg::SIM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/edit_distance_similarity_unit.sv @@
// top level: string loading, table sequencer and similarity result
//
//  channel  | strobe / hold  | fields
//  ---------+----------------+-------------------------------------------------
//  command  | start / busy   | kind, code_point
//  result   | done (1 cycle) | distance, longer_length, similarity, too_long
//
// an append beat never raises busy
// a compute beat with both strings loaded keeps busy high through the
// table and divider: one table cell per cycle through the cost row ram, a
// restart between rows, then 17 divider steps
// a compute beat with an empty string answers on the next cycle
// rst_n clears counts, flag and sequencer; the string and row rams hold
// no reset and are only read where written; results cannot be held off
module edit_distance_similarity_unit #(
    parameter int MAX_LEN = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    kind,
    input  logic [eds_pkg::CODE_W-1:0]    code_point,
    output logic                          done,
    output logic [eds_pkg::LEN_OUT_W-1:0] distance,
    output logic [eds_pkg::LEN_OUT_W-1:0] longer_length,
    output logic [eds_pkg::SIM_W-1:0]     similarity,
    output logic                          too_long
);

    localparam int CW     = $clog2(MAX_LEN + 1);
    localparam int IW     = $clog2(MAX_LEN);
    localparam int RowLen = MAX_LEN + 1;
    localparam int CAW    = $clog2(3 * RowLen);
    localparam int OutW   = eds_pkg::LEN_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_RUN,
        ST_CLAMP,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] n1_reg, n1_next;
    logic [CW-1:0] n2_reg, n2_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] ji_reg, ji_next;
    logic          issue_on_reg, issue_on_next;
    logic [CW-1:0] jc_reg, jc_next;
    logic          cv_reg, cv_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] upprev_reg, upprev_next;
    logic [1:0]    cur_slot_reg, cur_slot_next;
    logic [1:0]    up_slot_reg, up_slot_next;
    logic [1:0]    up2_slot_reg, up2_slot_next;
    logic [CW-1:0] dist_reg, dist_next;
    logic [CW-1:0] longer_reg, longer_next;
    logic [eds_pkg::SIM_W-1:0] sim_reg, sim_next;
    logic          too_long_reg, too_long_next;
    logic          done_reg, done_next;

    logic                      accept;
    logic [CW-1:0]             max_len_c;
    logic [CW-1:0]             i_m1;
    logic [CW-1:0]             i_m2;
    logic [CW-1:0]             ji_m1;
    logic [CW-1:0]             ji_m2;
    logic [CW-1:0]             longest;
    logic [CW-1:0]             clamped;

    logic                      t1_we;
    logic                      t2_we;
    logic [eds_pkg::CODE_W-1:0] t1_rd_a;
    logic [eds_pkg::CODE_W-1:0] t1_rd_b;
    logic [eds_pkg::CODE_W-1:0] t2_rd_a;
    logic [eds_pkg::CODE_W-1:0] t2_rd_b;

    logic                      c_we;
    logic [CAW-1:0]            c_waddr;
    logic [CW-1:0]             c_wdata;
    logic [CAW-1:0]            c_raddr_a;
    logic [CAW-1:0]            c_raddr_b;
    logic [CW-1:0]             c_rd_a;
    logic [CW-1:0]             c_rd_b;

    eds_pkg::eds_match_t       match;
    logic [CW-1:0]             cell_v;

    logic                      div_start;
    logic [CW-1:0]             div_numer;
    logic                      div_done;
    logic [eds_pkg::SIM_W-1:0] div_q;

    function automatic logic [CAW-1:0] slot_base(input logic [1:0] s);
        logic [CAW-1:0] b;
        case (s)
            2'd1:    b = CAW'(RowLen);
            2'd2:    b = CAW'(2 * RowLen);
            default: b = '0;
        endcase
        return b;
    endfunction

    assign accept    = start && !busy;
    assign max_len_c = CW'(MAX_LEN);
    assign i_m1      = i_reg - CW'(1);
    assign i_m2      = i_reg - CW'(2);
    assign ji_m1     = ji_reg - CW'(1);
    assign ji_m2     = ji_reg - CW'(2);
    assign longest   = (n1_reg > n2_reg) ? n1_reg : n2_reg;
    assign clamped   = (dist_reg > longer_reg) ? longer_reg : dist_reg;

    assign t1_we = accept && (kind == eds_pkg::KIND_FIRST) && (n1_reg < max_len_c);
    assign t2_we = accept && (kind == eds_pkg::KIND_SECOND) && (n2_reg < max_len_c);

    eds_ram #(
        .WIDTH(eds_pkg::CODE_W),
        .DEPTH(MAX_LEN)
    ) u_first_text (
        .clk     (clk),
        .we      (t1_we),
        .waddr   (n1_reg[IW-1:0]),
        .wdata   (code_point),
        .raddr_a (i_m1[IW-1:0]),
        .rdata_a (t1_rd_a),
        .raddr_b (i_m2[IW-1:0]),
        .rdata_b (t1_rd_b)
    );

    eds_ram #(
        .WIDTH(eds_pkg::CODE_W),
        .DEPTH(MAX_LEN)
    ) u_second_text (
        .clk     (clk),
        .we      (t2_we),
        .waddr   (n2_reg[IW-1:0]),
        .wdata   (code_point),
        .raddr_a (ji_m1[IW-1:0]),
        .rdata_a (t2_rd_a),
        .raddr_b (ji_m2[IW-1:0]),
        .rdata_b (t2_rd_b)
    );

    // three rolling rows, each at its own base
    always_comb
    begin
        c_we      = 1'b0;
        c_waddr   = slot_base(cur_slot_reg);
        c_wdata   = i_reg;
        c_raddr_a = slot_base(up_slot_reg) + CAW'(ji_reg);
        c_raddr_b = slot_base(up2_slot_reg) + CAW'(ji_m2);
        unique case (state_reg)
            ST_INIT:
            begin
                c_we    = 1'b1;
                c_waddr = slot_base(up_slot_reg) + CAW'(ji_reg);
                c_wdata = ji_reg;
            end
            ST_ROW:
            begin
                c_we    = 1'b1;
                c_waddr = slot_base(cur_slot_reg);
                c_wdata = i_reg;
            end
            ST_RUN:
            begin
                c_we    = cv_reg;
                c_waddr = slot_base(cur_slot_reg) + CAW'(jc_reg);
                c_wdata = cell_v;
            end
            default:
            begin
                c_we = 1'b0;
            end
        endcase
    end

    eds_ram #(
        .WIDTH(CW),
        .DEPTH(3 * RowLen)
    ) u_cost_rows (
        .clk     (clk),
        .we      (c_we),
        .waddr   (c_waddr),
        .wdata   (c_wdata),
        .raddr_a (c_raddr_a),
        .rdata_a (c_rd_a),
        .raddr_b (c_raddr_b),
        .rdata_b (c_rd_b)
    );

    always_comb
    begin
        match.sub_diff = (t1_rd_a != t2_rd_a);
        match.cross_a  = (t1_rd_b != t2_rd_a);
        match.cross_b  = (t1_rd_a != t2_rd_b);
        match.trans_en = (i_reg > CW'(2)) && (jc_reg > CW'(2));
    end

    eds_cell #(
        .W(CW)
    ) u_cell (
        .up    (c_rd_a),
        .diag  (upprev_reg),
        .left  (left_reg),
        .up2   (c_rd_b),
        .match (match),
        .v     (cell_v)
    );

    assign div_start = (state_reg == ST_CLAMP);
    assign div_numer = longer_reg - clamped;

    eds_divider #(
        .W(CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (longer_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        n1_next       = n1_reg;
        n2_next       = n2_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        ji_next       = ji_reg;
        issue_on_next = issue_on_reg;
        jc_next       = jc_reg;
        cv_next       = 1'b0;
        left_next     = left_reg;
        upprev_next   = upprev_reg;
        cur_slot_next = cur_slot_reg;
        up_slot_next  = up_slot_reg;
        up2_slot_next = up2_slot_reg;
        dist_next     = dist_reg;
        longer_next   = longer_reg;
        sim_next      = sim_reg;
        too_long_next = too_long_reg;
        done_next     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        eds_pkg::KIND_FIRST:
                        begin
                            if (n1_reg < max_len_c)
                                n1_next = n1_reg + CW'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        eds_pkg::KIND_SECOND:
                        begin
                            if (n2_reg < max_len_c)
                                n2_next = n2_reg + CW'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        eds_pkg::KIND_COMPUTE:
                        begin
                            longer_next   = longest;
                            too_long_next = ovf_reg;
                            if ((n1_reg == '0) || (n2_reg == '0))
                            begin
                                // empty string: answer at once
                                dist_next = longest;
                                sim_next  = '0;
                                done_next = 1'b1;
                                n1_next   = '0;
                                n2_next   = '0;
                                ovf_next  = 1'b0;
                            end
                            else
                            begin
                                ji_next       = '0;
                                cur_slot_next = 2'd1;
                                up_slot_next  = 2'd0;
                                up2_slot_next = 2'd2;
                                state_next    = ST_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                // row zero holds its own column index
                if (ji_reg == n2_reg)
                begin
                    i_next     = CW'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    ji_next = ji_reg + CW'(1);
                end
            end
            ST_ROW:
            begin
                left_next     = i_reg;
                upprev_next   = i_m1;
                ji_next       = CW'(1);
                issue_on_next = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                // issue reads for column ji, compute column jc in the next cycle
                if (issue_on_reg)
                begin
                    jc_next = ji_reg;
                    cv_next = 1'b1;
                    if (ji_reg == n2_reg)
                        issue_on_next = 1'b0;
                    else
                        ji_next = ji_reg + CW'(1);
                end
                if (cv_reg)
                begin
                    left_next   = cell_v;
                    upprev_next = c_rd_a;
                    if (jc_reg == n2_reg)
                    begin
                        if (i_reg == n1_reg)
                        begin
                            dist_next  = cell_v;
                            state_next = ST_CLAMP;
                        end
                        else
                        begin
                            i_next        = i_reg + CW'(1);
                            cur_slot_next = up2_slot_reg;
                            up_slot_next  = cur_slot_reg;
                            up2_slot_next = up_slot_reg;
                            state_next    = ST_ROW;
                        end
                    end
                end
            end
            ST_CLAMP:
            begin
                dist_next  = clamped;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    sim_next   = div_q;
                    done_next  = 1'b1;
                    n1_next    = '0;
                    n2_next    = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n1_reg       <= '0;
            n2_reg       <= '0;
            ovf_reg      <= 1'b0;
            issue_on_reg <= 1'b0;
            cv_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n1_reg       <= n1_next;
            n2_reg       <= n2_next;
            ovf_reg      <= ovf_next;
            issue_on_reg <= issue_on_next;
            cv_reg       <= cv_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        ji_reg       <= ji_next;
        jc_reg       <= jc_next;
        left_reg     <= left_next;
        upprev_reg   <= upprev_next;
        cur_slot_reg <= cur_slot_next;
        up_slot_reg  <= up_slot_next;
        up2_slot_reg <= up2_slot_next;
        dist_reg     <= dist_next;
        longer_reg   <= longer_next;
        sim_reg      <= sim_next;
        too_long_reg <= too_long_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign distance      = OutW'(dist_reg);
    assign longer_length = OutW'(longer_reg);
    assign similarity    = sim_reg;
    assign too_long      = too_long_reg;

endmodule

@@ hdl/eds_checker.sv @@
// port-level checks of the edit distance similarity unit, bound to the top
`include "edit_distance_similarity_unit_defines.svh"

module eds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    kind,
    input logic [eds_pkg::CODE_W-1:0]    code_point,
    input logic                          done,
    input logic [eds_pkg::LEN_OUT_W-1:0] distance,
    input logic [eds_pkg::LEN_OUT_W-1:0] longer_length,
    input logic [eds_pkg::SIM_W-1:0]     similarity,
    input logic                          too_long
);

    localparam logic [eds_pkg::SIM_W-1:0] SimOne = eds_pkg::SIM_W'(1 << eds_pkg::FRAC_W);

    logic non_compute_beat;
    logic result_seen;

    assign non_compute_beat = start && !busy && ((kind == eds_pkg::KIND_FIRST)
                              || (kind == eds_pkg::KIND_SECOND)
                              || (kind == eds_pkg::KIND_UNUSED));
    // keep the payload ports in the checker's view
    assign result_seen = done && ((code_point == code_point) || too_long
                         || (longer_length == longer_length));

    // a result beat leaves the unit free for the next command
    `EDS_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)
    // a long compute only ends with its result beat
    `EDS_ASSERT_IMP(a_busy_ends_in_done, clk, rst_n, $fell(busy), done)
    // appends and unused kinds never cause a result
    `EDS_ASSERT_NXT(a_no_result_for_append, clk, rst_n, non_compute_beat, !done)
    // full similarity only for a zero distance
    `EDS_ASSERT_IMP(a_full_sim_zero_dist, clk, rst_n,
        result_seen && (similarity == SimOne), distance == '0)

endmodule

bind edit_distance_similarity_unit eds_checker u_eds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .code_point    (code_point),
    .done          (done),
    .distance      (distance),
    .longer_length (longer_length),
    .similarity    (similarity),
    .too_long      (too_long)
);
